>>> hw/rtl/tstc_pkg.sv
`default_nettype none
package tstc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef logic [TimeW-1:0] ms_t;
  typedef logic [1:0] phase_t;
  typedef logic [1:0] action_t;
  typedef logic [2:0] cmd_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam phase_t PhaseStopped = 2'd0;
  localparam phase_t PhaseRunning = 2'd1;
  localparam phase_t PhasePaused  = 2'd2;

  localparam action_t ActNone  = 2'd0;
  localparam action_t ActStart = 2'd1;
  localparam action_t ActStop  = 2'd2;
  localparam action_t ActReset = 2'd3;

  localparam cmd_t CmdNone   = 3'd0;
  localparam cmd_t CmdStart  = 3'd1;
  localparam cmd_t CmdStop   = 3'd2;
  localparam cmd_t CmdReset  = 3'd3;
  localparam cmd_t CmdSilent = 3'd4;

  localparam cfg_idx_t RegInactEn    = 3'd0;
  localparam cfg_idx_t RegInactLimit = 3'd1;
  localparam cfg_idx_t RegHoldLimit  = 3'd2;
  localparam cfg_idx_t RegPressDeb   = 3'd3;
  localparam cfg_idx_t RegReleaseDeb = 3'd4;
  localparam cfg_idx_t RegTapLockout = 3'd5;
  localparam cfg_idx_t RegCancelWin  = 3'd6;

  localparam ms_t CountdownTotalMs = 32'd4000;
  localparam ms_t CountdownLeadMs  = 32'd1500;
  localparam logic [11:0] DigitPeriodMs = 12'd1000;
  localparam logic [11:0] DigitShowMs   = 12'd100;

  localparam ms_t InactLimitRst = 32'd600000;
  localparam logic [15:0] HoldLimitRst = 16'd3000;
  localparam logic [9:0] PressDebRst = 10'd50;
  localparam logic [9:0] ReleaseDebRst = 10'd200;
  localparam logic [9:0] TapLockoutRst = 10'd300;
  localparam logic [11:0] CancelWinRst = 12'd1000;

  typedef struct packed {
    ms_t  now_ms;
    logic touch_level;
    logic activity_pulse;
    cmd_t timer_command;
  } step_t;

  typedef struct packed {
    logic       show_sleep_notice;
    logic       show_cancel_notice;
    logic [1:0] countdown_digit;
    logic       enter_sleep;
    action_t    timer_action;
    phase_t     timer_phase;
    logic       countdown_running;
  } result_t;

  typedef struct packed {
    cfg_idx_t              index;
    logic [CfgDataW-1:0]   data;
  } cfg_wr_t;

endpackage
`default_nettype wire

>>> hw/rtl/tstc_ifs.sv
`default_nettype none
interface tstc_step_if
  import tstc_pkg::*;
  ();
  logic  valid;
  logic  ready;
  step_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tstc_result_if
  import tstc_pkg::*;
  ();
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tstc_cfg_if
  import tstc_pkg::*;
  ();
  logic    valid;
  logic    ready;
  cfg_wr_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/touch_sleep_timer_controller_top.sv
// Channel   Dir  Request payload
// step_i    in   now_ms, touch_level, activity_pulse, timer_command
// result_o  out  notices, countdown_digit, enter_sleep, timer action/phase, running
// cfg_i     in   register index, write data (always ready)
//
// One request per clock while result_o is not stalled: a step register feeds the
// controller logic, whose outcome and state update land in the result register
// in the same cycle; each step goes through the step, then the result register.
// A stalled result holds the result register; the step register keeps one
// more request, then step_i.ready drops.
// rst_ni clears all controller state and loads the register defaults.
`default_nettype none
module touch_sleep_timer_controller_top
  import tstc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  tstc_step_if.sink         step_i,
  tstc_result_if.source     result_o,
  tstc_cfg_if.sink          cfg_i
);

  logic        inact_en_q;
  ms_t         inact_limit_q;
  logic [15:0] hold_limit_q;
  logic [9:0]  press_deb_q, release_deb_q, tap_lockout_q;
  logic [11:0] cancel_win_q;

  logic   stable_q, stable_d;
  ms_t    last_change_q, last_change_d;
  ms_t    press_start_q, press_start_d;
  logic   cd_q, cd_d;
  ms_t    cd_start_q, cd_start_d;
  logic   rc_q, rc_d;
  ms_t    cancel_stamp_q, cancel_stamp_d;
  ms_t    act_q, act_d;
  phase_t phase_q, phase_d;
  ms_t    last_tap_q, last_tap_d;
  logic   asleep_q, asleep_d;

  logic    in_vld_q;
  step_t   in_q;
  logic    out_vld_q;
  result_t out_q, res_d;
  logic    advance;

  ms_t  e_cd, dt_cancel, dt_change, dt_press, dt_tap, dt_act;
  ms_t  act1;
  logic cd1, rc1, deb_ok;
  logic [9:0]  need;
  logic [11:0] d_cd;
  logic [11:0] d_mod;
  logic [1:0]  d_rem;

  assign advance = in_vld_q && (!out_vld_q || result_o.ready);
  assign step_i.ready = !in_vld_q || advance;
  assign cfg_i.ready = 1'b1;
  assign result_o.valid = out_vld_q;
  assign result_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inact_en_q    <= 1'b1;
      inact_limit_q <= InactLimitRst;
      hold_limit_q  <= HoldLimitRst;
      press_deb_q   <= PressDebRst;
      release_deb_q <= ReleaseDebRst;
      tap_lockout_q <= TapLockoutRst;
      cancel_win_q  <= CancelWinRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        RegInactEn:    inact_en_q    <= cfg_i.payload.data[0];
        RegInactLimit: inact_limit_q <= cfg_i.payload.data;
        RegHoldLimit:  hold_limit_q  <= cfg_i.payload.data[15:0];
        RegPressDeb:   press_deb_q   <= cfg_i.payload.data[9:0];
        RegReleaseDeb: release_deb_q <= cfg_i.payload.data[9:0];
        RegTapLockout: tap_lockout_q <= cfg_i.payload.data[9:0];
        RegCancelWin:  cancel_win_q  <= cfg_i.payload.data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (step_i.ready) in_vld_q <= step_i.valid;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.ready && step_i.valid) in_q <= step_i.payload;
    if (advance) out_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q       <= 1'b0;
      last_change_q  <= '0;
      press_start_q  <= '0;
      cd_q           <= 1'b0;
      cd_start_q     <= '0;
      rc_q           <= 1'b0;
      cancel_stamp_q <= '0;
      act_q          <= '0;
      phase_q        <= PhaseStopped;
      last_tap_q     <= '0;
      asleep_q       <= 1'b0;
    end else if (advance) begin
      stable_q       <= stable_d;
      last_change_q  <= last_change_d;
      press_start_q  <= press_start_d;
      cd_q           <= cd_d;
      cd_start_q     <= cd_start_d;
      rc_q           <= rc_d;
      cancel_stamp_q <= cancel_stamp_d;
      act_q          <= act_d;
      phase_q        <= phase_d;
      last_tap_q     <= last_tap_d;
      asleep_q       <= asleep_d;
    end
  end

  assign e_cd      = in_q.now_ms - cd_start_q;
  assign d_cd      = e_cd[11:0] - CountdownLeadMs[11:0];
  assign dt_cancel = in_q.now_ms - cancel_stamp_q;
  assign dt_change = in_q.now_ms - last_change_q;
  assign dt_press  = in_q.now_ms - press_start_q;
  assign dt_tap    = in_q.now_ms - last_tap_q;
  assign need      = in_q.touch_level ? press_deb_q : release_deb_q;
  assign deb_ok    = (in_q.touch_level != stable_q) && (dt_change > {22'd0, need});

  // map the lead-relative countdown time to a digit (3 down to 1) and its offset within that second
  always_comb begin
    if (d_cd < DigitPeriodMs) begin
      d_rem = 2'd3;
      d_mod = d_cd;
    end else if (d_cd < 12'd2000) begin
      d_rem = 2'd2;
      d_mod = d_cd - DigitPeriodMs;
    end else begin
      d_rem = 2'd1;
      d_mod = d_cd - 12'd2000;
    end
  end

  always_comb begin
    stable_d       = stable_q;
    last_change_d  = last_change_q;
    press_start_d  = press_start_q;
    cd_d           = cd_q;
    cd_start_d     = cd_start_q;
    rc_d           = rc_q;
    cancel_stamp_d = cancel_stamp_q;
    act_d          = act_q;
    phase_d        = phase_q;
    last_tap_d     = last_tap_q;
    asleep_d       = asleep_q;
    res_d          = '0;
    act1           = act_q;
    cd1            = cd_q;
    rc1            = rc_q;
    dt_act         = '0;

    if (!asleep_q) begin
      if (in_q.activity_pulse) act_d = in_q.now_ms;

      case (in_q.timer_command)
        CmdStart: begin
          res_d.timer_action = ActStart;
          phase_d = PhaseRunning;
        end
        CmdStop: begin
          res_d.timer_action = ActStop;
          phase_d = PhasePaused;
        end
        CmdReset: begin
          res_d.timer_action = ActReset;
          phase_d = PhaseStopped;
        end
        CmdSilent: phase_d = PhaseStopped;
        default: ;
      endcase

      if (rc_q && (dt_cancel > {20'd0, cancel_win_q})) rc_d = 1'b0;
      rc1 = rc_d;

      if (cd_q) begin
        if (e_cd < CountdownTotalMs) begin
          if (e_cd > CountdownLeadMs && d_mod < DigitShowMs) res_d.countdown_digit = d_rem;
        end else begin
          res_d.enter_sleep = 1'b1;
          cd_d = 1'b0;
          asleep_d = 1'b1;
        end
      end
      cd1 = cd_d;

      if (!res_d.enter_sleep) begin
        if (deb_ok) begin
          if (in_q.touch_level) begin
            if (cd1) begin
              cd_d = 1'b0;
              rc_d = 1'b1;
              cancel_stamp_d = in_q.now_ms;
              act_d = in_q.now_ms;
              res_d.show_cancel_notice = 1'b1;
            end else if (!rc1) begin
              press_start_d = in_q.now_ms;
              act_d = in_q.now_ms;
            end
          end else if (!cd1 && !rc1) begin
            if (dt_press >= {16'd0, hold_limit_q}) begin
              cd_d = 1'b1;
              cd_start_d = in_q.now_ms;
              res_d.show_sleep_notice = 1'b1;
            end else if (dt_tap >= {22'd0, tap_lockout_q}) begin
              last_tap_d = in_q.now_ms;
              case (phase_d)
                PhaseRunning: begin
                  res_d.timer_action = ActStop;
                  phase_d = PhasePaused;
                end
                PhasePaused: begin
                  res_d.timer_action = ActReset;
                  phase_d = PhaseStopped;
                end
                default: begin
                  res_d.timer_action = ActStart;
                  phase_d = PhaseRunning;
                end
              endcase
            end
          end
          stable_d = in_q.touch_level;
          last_change_d = in_q.now_ms;
        end

        act1 = act_d;
        dt_act = in_q.now_ms - act1;
        if (inact_en_q && (inact_limit_q != '0) && !cd_d && !in_q.touch_level &&
            (dt_act >= inact_limit_q)) begin
          cd_d = 1'b1;
          cd_start_d = in_q.now_ms;
          act_d = in_q.now_ms;
          res_d.show_sleep_notice = 1'b1;
        end
      end

      res_d.countdown_running = cd_d;
    end
    res_d.timer_phase = phase_d;
  end

endmodule
`default_nettype wire

>>> hw/rtl/tstc_checker.sv
`default_nettype none
module tstc_checker
  import tstc_pkg::*;
(
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    res_valid_i,
  input wire logic    res_ready_i,
  input wire result_t res_i
);

  logic    res_fire;
  logic    slept_q;

  assign res_fire = res_valid_i && res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slept_q <= 1'b0;
    end else if (res_fire && res_i.enter_sleep) begin
      slept_q <= 1'b1;
    end
  end

  a_expiry_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire && res_i.enter_sleep |-> !res_i.countdown_running)
    else $error("countdown still running on expiry");

  a_asleep_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire && slept_q |-> !res_i.enter_sleep && !res_i.show_sleep_notice &&
      !res_i.show_cancel_notice && res_i.countdown_digit == 2'd0 &&
      res_i.timer_action == ActNone && !res_i.countdown_running)
    else $error("activity reported after sleep");

  a_cancel_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire && res_i.show_cancel_notice |->
      !res_i.show_sleep_notice && !res_i.countdown_running)
    else $error("cancel left countdown active");

  a_notice_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire && res_i.show_sleep_notice |->
      res_i.countdown_running && res_i.countdown_digit == 2'd0)
    else $error("sleep notice without fresh countdown");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_i))
    else $error("stalled result dropped or changed");

endmodule

bind touch_sleep_timer_controller_top tstc_checker u_tstc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .res_valid_i(result_o.valid),
  .res_ready_i(result_o.ready),
  .res_i      (result_o.payload)
);
`default_nettype wire
